>>> design/lcd_pkg.sv
package lcd_pkg;

   localparam int SLOTS = 24;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   localparam logic [31:0] MAX_SIZE_RESET = 32'(64 * 1024);

   typedef enum logic [1:0] {
      CMD_LOOKUP       = 2'd0,
      CMD_INSERT       = 2'd1,
      CMD_CLEAR_ALL    = 2'd2,
      CMD_CLEAR_PINNED = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STS_HIT        = 3'd0,
      STS_MISS       = 3'd1,
      STS_STORED     = 3'd2,
      STS_ZERO       = 3'd3,
      STS_TOO_LARGE  = 3'd4,
      STS_NO_DATA    = 3'd5,
      STS_ALL_PINNED = 3'd6,
      STS_CLEARED    = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

endpackage

>>> design/lru_cache_directory_with_pinning_top.sv
// Fully associative LRU directory of 24 slots keyed by a 12-byte name, with pinned
// entries that are never evicted. Each command passes through these steps: the
// cycle in which the request is accepted (slot 0 is read during it), a scan of one
// slot per cycle in ST_SCAN while a single key comparator and a single stamp
// comparator walk the slots in order (this scan also performs the clear commands
// and counts freed slots), and a finish step in ST_FINISH that waits until the
// result register is free, then updates the chosen slot and loads the result word.
// req_stall is high from acceptance until the result is loaded, and longer while
// the previous result word still waits on rsp_stall; the result register holds its
// word until the consumer takes it, so a new request may be accepted meanwhile. The
// max_entry_size register must be written only while the block is idle.
module lru_cache_directory_with_pinning_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lcd_pkg::cmd_type    req_cmd,
   input  logic [63:0]         req_key_low,
   input  logic [31:0]         req_key_high,
   input  logic [31:0]         req_entry_size,
   input  logic                req_pin,
   input  logic                req_has_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lcd_pkg::status_type rsp_status,
   output logic [4:0]          rsp_slot,
   output logic [31:0]         rsp_hit_size,
   output logic                rsp_evicted,
   output logic [4:0]          rsp_freed_count,
   input  logic                csr_write_enable,
   input  logic [31:0]         csr_write_data
);
   import lcd_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   // Control state.
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic [SLOTS-1:0]  pinned_ff, pinned_in;
   logic [31:0]       use_cnt_ff, use_cnt_in;
   logic [31:0]       max_size_ff, max_size_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Captured request.
   cmd_type           cmd_ff, cmd_in;
   logic [63:0]       key_low_ff, key_low_in;
   logic [31:0]       key_high_ff, key_high_in;
   logic [31:0]       size_ff, size_in;
   logic              pin_ff, pin_in;
   logic              has_data_ff, has_data_in;

   // Scan results.
   logic              hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [31:0]       hit_size_ff, hit_size_in;
   logic              empty_found_ff, empty_found_in;
   logic [IDX_W-1:0]  empty_idx_ff, empty_idx_in;
   logic              old_found_ff, old_found_in;
   logic [IDX_W-1:0]  old_idx_ff, old_idx_in;
   logic [31:0]       oldest_ff, oldest_in;
   logic [CNT_W-1:0]  freed_ff, freed_in;

   // Result register.
   status_type        rsp_status_ff, rsp_status_in;
   logic [4:0]        rsp_slot_ff, rsp_slot_in;
   logic [31:0]       rsp_hit_size_ff, rsp_hit_size_in;
   logic              rsp_evicted_ff, rsp_evicted_in;
   logic [4:0]        rsp_freed_ff, rsp_freed_in;

   // Slot stores.
   logic [63:0]       slot_key_low_ff  [SLOTS];
   logic [31:0]       slot_key_high_ff [SLOTS];
   logic [31:0]       slot_size_ff     [SLOTS];
   logic [31:0]       slot_stamp_ff    [SLOTS];

   // Registered read data of the slot stores.
   logic [63:0]       rd_key_low_ff;
   logic [31:0]       rd_key_high_ff;
   logic [31:0]       rd_size_ff;
   logic [31:0]       rd_stamp_ff;

   logic              ent_we;
   logic              stamp_we;
   logic [IDX_W-1:0]  wr_idx;
   logic [IDX_W-1:0]  rd_idx;
   logic [31:0]       new_stamp;
   logic [IDX_W-1:0]  vic_idx;
   logic              key_match;
   logic              clear_hit;
   logic              out_free;

   // The read runs one slot ahead of the scan, so during the scan the read data
   // belongs to the slot idx_ff points at. Slot 0 is read while the block is idle.
   assign rd_idx    = (state_ff == ST_SCAN && idx_ff != LAST_IDX) ? idx_ff + IDX_W'(1) : '0;
   assign new_stamp = use_cnt_ff + 32'd1;
   assign vic_idx   = empty_found_ff ? empty_idx_ff : old_idx_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign key_match = valid_ff[idx_ff] && (rd_key_low_ff == key_low_ff)
                      && (rd_key_high_ff == key_high_ff);
   assign clear_hit = valid_ff[idx_ff] && ((cmd_ff == CMD_CLEAR_ALL) || pinned_ff[idx_ff]);

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      valid_in        = valid_ff;
      pinned_in       = pinned_ff;
      use_cnt_in      = use_cnt_ff;
      max_size_in     = csr_write_enable ? csr_write_data : max_size_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      cmd_in          = cmd_ff;
      key_low_in      = key_low_ff;
      key_high_in     = key_high_ff;
      size_in         = size_ff;
      pin_in          = pin_ff;
      has_data_in     = has_data_ff;
      hit_found_in    = hit_found_ff;
      hit_idx_in      = hit_idx_ff;
      hit_size_in     = hit_size_ff;
      empty_found_in  = empty_found_ff;
      empty_idx_in    = empty_idx_ff;
      old_found_in    = old_found_ff;
      old_idx_in      = old_idx_ff;
      oldest_in       = oldest_ff;
      freed_in        = freed_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_hit_size_in = rsp_hit_size_ff;
      rsp_evicted_in  = rsp_evicted_ff;
      rsp_freed_in    = rsp_freed_ff;
      ent_we          = 1'b0;
      stamp_we        = 1'b0;
      wr_idx          = vic_idx;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in         = req_cmd;
               key_low_in     = req_key_low;
               key_high_in    = req_key_high;
               size_in        = req_entry_size;
               pin_in         = req_pin;
               has_data_in    = req_has_data;
               idx_in         = '0;
               hit_found_in   = 1'b0;
               hit_idx_in     = '0;
               hit_size_in    = '0;
               empty_found_in = 1'b0;
               empty_idx_in   = '0;
               old_found_in   = 1'b0;
               old_idx_in     = '0;
               oldest_in      = '0;
               freed_in       = '0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cmd_ff == CMD_LOOKUP || cmd_ff == CMD_INSERT) begin
               if (key_match && !hit_found_ff) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = idx_ff;
                  hit_size_in  = rd_size_ff;
               end
               if (!valid_ff[idx_ff] && !empty_found_ff) begin
                  empty_found_in = 1'b1;
                  empty_idx_in   = idx_ff;
               end
               // Strict compare keeps the lowest index on equal stamps.
               if (valid_ff[idx_ff] && !pinned_ff[idx_ff]
                   && (!old_found_ff || rd_stamp_ff < oldest_ff)) begin
                  old_found_in = 1'b1;
                  old_idx_in   = idx_ff;
                  oldest_in    = rd_stamp_ff;
               end
            end else begin
               if (clear_hit) begin
                  valid_in[idx_ff]  = 1'b0;
                  pinned_in[idx_ff] = 1'b0;
                  freed_in          = freed_ff + CNT_W'(1);
               end
               if (cmd_ff == CMD_CLEAR_ALL) begin
                  pinned_in[idx_ff] = 1'b0;
               end
            end
            if (idx_ff == LAST_IDX) begin
               state_in = ST_FINISH;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in        = ST_IDLE;
               rsp_valid_in    = 1'b1;
               rsp_status_in   = STS_MISS;
               rsp_slot_in     = '0;
               rsp_hit_size_in = '0;
               rsp_evicted_in  = 1'b0;
               rsp_freed_in    = '0;
               case (cmd_ff)
                  CMD_LOOKUP: begin
                     if (hit_found_ff) begin
                        stamp_we        = 1'b1;
                        wr_idx          = hit_idx_ff;
                        use_cnt_in      = new_stamp;
                        rsp_status_in   = STS_HIT;
                        rsp_slot_in     = 5'(hit_idx_ff);
                        rsp_hit_size_in = hit_size_ff;
                     end
                  end
                  CMD_INSERT: begin
                     if (size_ff == 32'd0) begin
                        rsp_status_in = STS_ZERO;
                     end else if (!pin_ff && size_ff > max_size_ff) begin
                        rsp_status_in = STS_TOO_LARGE;
                     end else if (hit_found_ff) begin
                        // A refresh may pin an entry but never unpins one.
                        if (pin_ff) begin
                           pinned_in[hit_idx_ff] = 1'b1;
                        end
                        stamp_we      = 1'b1;
                        wr_idx        = hit_idx_ff;
                        use_cnt_in    = new_stamp;
                        rsp_status_in = STS_HIT;
                        rsp_slot_in   = 5'(hit_idx_ff);
                     end else if (!has_data_ff) begin
                        rsp_status_in = STS_NO_DATA;
                     end else if (!empty_found_ff && !old_found_ff) begin
                        rsp_status_in = STS_ALL_PINNED;
                     end else begin
                        ent_we             = 1'b1;
                        stamp_we           = 1'b1;
                        wr_idx             = vic_idx;
                        valid_in[vic_idx]  = 1'b1;
                        pinned_in[vic_idx] = pin_ff;
                        use_cnt_in         = new_stamp;
                        rsp_status_in      = STS_STORED;
                        rsp_slot_in        = 5'(vic_idx);
                        rsp_evicted_in     = !empty_found_ff;
                     end
                  end
                  default: begin
                     rsp_status_in = STS_CLEARED;
                     rsp_freed_in  = 5'(freed_ff);
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         valid_ff     <= '0;
         pinned_ff    <= '0;
         use_cnt_ff   <= '0;
         max_size_ff  <= MAX_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         valid_ff     <= valid_in;
         pinned_ff    <= pinned_in;
         use_cnt_ff   <= use_cnt_in;
         max_size_ff  <= max_size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      key_low_ff      <= key_low_in;
      key_high_ff     <= key_high_in;
      size_ff         <= size_in;
      pin_ff          <= pin_in;
      has_data_ff     <= has_data_in;
      hit_found_ff    <= hit_found_in;
      hit_idx_ff      <= hit_idx_in;
      hit_size_ff     <= hit_size_in;
      empty_found_ff  <= empty_found_in;
      empty_idx_ff    <= empty_idx_in;
      old_found_ff    <= old_found_in;
      old_idx_ff      <= old_idx_in;
      oldest_ff       <= oldest_in;
      freed_ff        <= freed_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_hit_size_ff <= rsp_hit_size_in;
      rsp_evicted_ff  <= rsp_evicted_in;
      rsp_freed_ff    <= rsp_freed_in;
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         slot_key_low_ff[wr_idx]  <= key_low_ff;
         slot_key_high_ff[wr_idx] <= key_high_ff;
         slot_size_ff[wr_idx]     <= size_ff;
      end
      if (stamp_we) begin
         slot_stamp_ff[wr_idx] <= new_stamp;
      end
      rd_key_low_ff  <= slot_key_low_ff[rd_idx];
      rd_key_high_ff <= slot_key_high_ff[rd_idx];
      rd_size_ff     <= slot_size_ff[rd_idx];
      rd_stamp_ff    <= slot_stamp_ff[rd_idx];
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_hit_size    = rsp_hit_size_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_freed_count = rsp_freed_ff;

endmodule

>>> tb/lru_cache_directory_with_pinning_top_tb.sv
`timescale 1ns / 1ps

module lru_cache_directory_with_pinning_top_tb;
   import lcd_pkg::*;

   typedef struct {
      cmd_type     cmd;
      logic [63:0] key_low;
      logic [31:0] key_high;
      logic [31:0] entry_size;
      logic        pin;
      logic        has_data;
   } dir_request_type;

   typedef struct {
      status_type  status;
      logic [4:0]  slot;
      logic [31:0] hit_size;
      logic        evicted;
      logic [4:0]  freed_count;
   } dir_result_type;

   class directory_scoreboard_type;
      logic        entry_valid    [SLOTS];
      logic        entry_pinned   [SLOTS];
      logic [63:0] entry_key_low  [SLOTS];
      logic [31:0] entry_key_high [SLOTS];
      logic [31:0] entry_bytes    [SLOTS];
      logic [31:0] entry_stamp    [SLOTS];
      logic [31:0] use_count;
      logic [31:0] size_limit;
      dir_result_type pending_results[$];
      int          failures;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            entry_valid[i] = 1'b0;
            entry_pinned[i] = 1'b0;
         end
         use_count = '0;
         size_limit = MAX_SIZE_RESET;
         failures = 0;
      endfunction

      function void set_limit(logic [31:0] value);
         size_limit = value;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function int find_entry(logic [63:0] klo, logic [31:0] khi);
         for (int i = 0; i < SLOTS; i++) begin
            if (entry_valid[i] && entry_key_low[i] == klo && entry_key_high[i] == khi) begin
               return i;
            end
         end
         return -1;
      endfunction

      function logic [31:0] next_stamp();
         use_count = use_count + 32'd1;
         return use_count;
      endfunction

      // Works out the result word of one accepted command and updates the directory.
      function void note_request(dir_request_type r);
         dir_result_type res;
         int          hit;
         int          victim;
         int          i;
         bit          found;
         bit          only_pinned;
         logic [31:0] oldest;
         res.status = STS_MISS;
         res.slot = '0;
         res.hit_size = '0;
         res.evicted = 1'b0;
         res.freed_count = '0;
         case (r.cmd)
            CMD_LOOKUP: begin
               hit = find_entry(r.key_low, r.key_high);
               if (hit >= 0) begin
                  entry_stamp[hit] = next_stamp();
                  res.status = STS_HIT;
                  res.slot = 5'(hit);
                  res.hit_size = entry_bytes[hit];
               end
            end
            CMD_INSERT: begin
               if (r.entry_size == 32'd0) begin
                  res.status = STS_ZERO;
               end else if (!r.pin && r.entry_size > size_limit) begin
                  res.status = STS_TOO_LARGE;
               end else begin
                  hit = find_entry(r.key_low, r.key_high);
                  if (hit >= 0) begin
                     // A refresh may pin an entry but never unpins one.
                     if (r.pin) entry_pinned[hit] = 1'b1;
                     entry_stamp[hit] = next_stamp();
                     res.status = STS_HIT;
                     res.slot = 5'(hit);
                  end else if (!r.has_data) begin
                     res.status = STS_NO_DATA;
                  end else begin
                     victim = -1;
                     found = 1'b0;
                     oldest = '0;
                     for (i = 0; i < SLOTS; i++) begin
                        if (!entry_valid[i]) begin
                           victim = i;
                           found = 1'b1;
                           break;
                        end
                        if (!entry_pinned[i] && (!found || entry_stamp[i] < oldest)) begin
                           oldest = entry_stamp[i];
                           victim = i;
                           found = 1'b1;
                        end
                     end
                     if (!found) begin
                        res.status = STS_ALL_PINNED;
                     end else begin
                        res.evicted = entry_valid[victim];
                        entry_valid[victim] = 1'b1;
                        entry_pinned[victim] = r.pin;
                        entry_key_low[victim] = r.key_low;
                        entry_key_high[victim] = r.key_high;
                        entry_bytes[victim] = r.entry_size;
                        entry_stamp[victim] = next_stamp();
                        res.status = STS_STORED;
                        res.slot = 5'(victim);
                     end
                  end
               end
            end
            default: begin
               only_pinned = (r.cmd == CMD_CLEAR_PINNED);
               for (i = 0; i < SLOTS; i++) begin
                  if (entry_valid[i] && (!only_pinned || entry_pinned[i])) begin
                     entry_valid[i] = 1'b0;
                     entry_pinned[i] = 1'b0;
                     res.freed_count = res.freed_count + 5'd1;
                  end
                  if (!only_pinned) entry_pinned[i] = 1'b0;
               end
               res.status = STS_CLEARED;
            end
         endcase
         pending_results.push_back(res);
      endfunction

      function void check_result(dir_result_type got);
         dir_result_type want;
         if (pending_results.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("%0t: unexpected result word: status %0d slot %0d size %0h %s",
                        $realtime, got.status, got.slot, got.hit_size,
                        $sformatf("evicted %0d freed %0d", got.evicted, got.freed_count));
            end
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status || got.slot !== want.slot ||
             got.hit_size !== want.hit_size || got.evicted !== want.evicted ||
             got.freed_count !== want.freed_count) begin
            failures++;
            if (failures <= 10) begin
               $display("%0t: mismatch: expected status %0d slot %0d size %0h %s",
                        $realtime, want.status, want.slot, want.hit_size,
                        $sformatf("evicted %0d freed %0d", want.evicted, want.freed_count));
               $display("%0t:           actual status %0d slot %0d size %0h %s",
                        $realtime, got.status, got.slot, got.hit_size,
                        $sformatf("evicted %0d freed %0d", got.evicted, got.freed_count));
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   cmd_type     req_cmd;
   logic [63:0] req_key_low;
   logic [31:0] req_key_high;
   logic [31:0] req_entry_size;
   logic        req_pin;
   logic        req_has_data;
   logic        rsp_valid;
   logic        rsp_stall;
   status_type  rsp_status;
   logic [4:0]  rsp_slot;
   logic [31:0] rsp_hit_size;
   logic        rsp_evicted;
   logic [4:0]  rsp_freed_count;
   logic        csr_write_enable;
   logic [31:0] csr_write_data;

   directory_scoreboard_type ledger = new();
   bit          allow_stall = 1'b1;
   int          stall_left = 0;
   logic [63:0] key_pool_low  [64];
   logic [31:0] key_pool_high [64];

   lru_cache_directory_with_pinning_top u_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Result side backpressure comes in bursts of random length.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (allow_stall && !reset && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 15);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      dir_result_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got.status = rsp_status;
         got.slot = rsp_slot;
         got.hit_size = rsp_hit_size;
         got.evicted = rsp_evicted;
         got.freed_count = rsp_freed_count;
         ledger.check_result(got);
      end
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic send_word(input dir_request_type r);
      @(negedge clock);
      req_valid <= 1'b1;
      req_cmd <= r.cmd;
      req_key_low <= r.key_low;
      req_key_high <= r.key_high;
      req_entry_size <= r.entry_size;
      req_pin <= r.pin;
      req_has_data <= r.has_data;
      do @(posedge clock); while (req_stall !== 1'b0);
      ledger.note_request(r);
   endtask

   task automatic send_fields(input cmd_type c, input logic [63:0] klo, input logic [31:0] khi,
                              input logic [31:0] bytes, input logic pin, input logic data);
      dir_request_type r;
      r.cmd = c;
      r.key_low = klo;
      r.key_high = khi;
      r.entry_size = bytes;
      r.pin = pin;
      r.has_data = data;
      send_word(r);
   endtask

   task automatic sender_pause(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic drain_requests();
      sender_pause(1);
      while (ledger.pending() != 0) @(posedge clock);
   endtask

   task automatic write_limit(input logic [31:0] value);
      drain_requests();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      ledger.set_limit(value);
   endtask

   task automatic send_random(input int span, input int pin_pct, input int fresh_pct,
                              input int clear_pct, input int insert_pct);
      dir_request_type r;
      int          pick;
      logic [31:0] cap;
      cap = ledger.size_limit;
      pick = $urandom_range(0, 99);
      if (pick < clear_pct) r.cmd = ($urandom_range(0, 1) != 0) ? CMD_CLEAR_PINNED : CMD_CLEAR_ALL;
      else if (pick < clear_pct + insert_pct) r.cmd = CMD_INSERT;
      else r.cmd = CMD_LOOKUP;
      if ($urandom_range(0, 99) < fresh_pct) begin
         r.key_low = {$urandom, $urandom};
         r.key_high = $urandom;
      end else begin
         pick = $urandom_range(0, span - 1);
         r.key_low = key_pool_low[pick];
         r.key_high = key_pool_high[pick];
      end
      case ($urandom_range(0, 19))
         0:       r.entry_size = '0;
         1:       r.entry_size = cap;
         2:       r.entry_size = cap + 32'd1;
         3:       r.entry_size = '1;
         4, 5:    r.entry_size = $urandom;
         default: r.entry_size = (cap == 0) ? 32'($urandom_range(1, 64)) :
                                 32'd1 + ($urandom % ((cap < 4096) ? cap : 32'd4096));
      endcase
      r.pin = ($urandom_range(0, 99) < pin_pct);
      r.has_data = ($urandom_range(0, 99) < 85);
      send_word(r);
   endtask

   initial begin
      logic [31:0] limits [5];
      int          sent;
      int          count;
      int          span;
      int          pin_pct;
      bit          quiet;
      bit          idle_on;
      bit          storm;

      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_LOOKUP;
      req_key_low = '0;
      req_key_high = '0;
      req_entry_size = '0;
      req_pin = 1'b0;
      req_has_data = 1'b0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;

      // Every fourth key has a low word that differs from the previous key's in one bit only.
      for (int i = 0; i < 64; i++) begin
         key_pool_low[i] = {$urandom, $urandom};
         key_pool_high[i] = $urandom;
         if (i % 4 == 3) begin
            key_pool_low[i] = key_pool_low[i - 1] ^ (64'd1 << $urandom_range(0, 63));
         end
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words under the reset size cap.
      send_fields(CMD_LOOKUP, key_pool_low[0], key_pool_high[0], '1, 1'b1, 1'b0);
      send_fields(CMD_INSERT, key_pool_low[0], key_pool_high[0], '0, 1'b0, 1'b1);
      send_fields(CMD_INSERT, key_pool_low[0], key_pool_high[0], '0, 1'b1, 1'b1);
      send_fields(CMD_INSERT, key_pool_low[0], key_pool_high[0], MAX_SIZE_RESET + 32'd1,
                  1'b0, 1'b1);
      send_fields(CMD_INSERT, key_pool_low[0], key_pool_high[0], MAX_SIZE_RESET, 1'b0, 1'b0);
      send_fields(CMD_INSERT, key_pool_low[0], key_pool_high[0], MAX_SIZE_RESET, 1'b0, 1'b1);
      send_fields(CMD_LOOKUP, key_pool_low[0], key_pool_high[0], '0, 1'b0, 1'b1);
      send_fields(CMD_LOOKUP, key_pool_low[0], ~key_pool_high[0], 32'd1, 1'b1, 1'b1);
      send_fields(CMD_INSERT, key_pool_low[1], key_pool_high[1], '1, 1'b1, 1'b1);
      send_fields(CMD_INSERT, key_pool_low[0], key_pool_high[0], 32'd5, 1'b1, 1'b0);
      send_fields(CMD_INSERT, key_pool_low[0], key_pool_high[0], 32'd5, 1'b0, 1'b1);
      // The size cap is checked before the key match.
      send_fields(CMD_INSERT, key_pool_low[1], key_pool_high[1], MAX_SIZE_RESET + 32'd1,
                  1'b0, 1'b1);
      send_fields(CMD_CLEAR_PINNED, '1, '1, '1, 1'b1, 1'b1);
      send_fields(CMD_INSERT, '1, '1, 32'd1, 1'b0, 1'b1);
      send_fields(CMD_INSERT, '0, '0, 32'd1, 1'b0, 1'b1);
      send_fields(CMD_LOOKUP, '1, '1, '0, 1'b0, 1'b0);
      send_fields(CMD_CLEAR_ALL, key_pool_low[0], key_pool_high[0], 32'd7, 1'b1, 1'b0);
      send_fields(CMD_CLEAR_ALL, '0, '0, '0, 1'b0, 1'b0);

      limits[0] = '0;
      limits[1] = '1;
      limits[2] = 32'd300;
      limits[3] = 32'($urandom_range(1, 1 << 20));
      limits[4] = MAX_SIZE_RESET;

      for (int phase = 0; phase < 5; phase++) begin
         write_limit(limits[phase]);
         quiet = (phase == 4);
         sent = 0;
         while (sent < 70) begin
            // A storm of pinned words with fresh keys fills the directory until inserts
            // are refused.
            storm = (phase == 2 && sent == 0) || $urandom_range(0, 9) == 0;
            count = storm ? 40 : $urandom_range(10, 30);
            case ($urandom_range(0, 3))
               0:       span = 6;
               1:       span = 16;
               2:       span = 28;
               default: span = 64;
            endcase
            case ($urandom_range(0, 2))
               0:       pin_pct = 0;
               1:       pin_pct = 10;
               default: pin_pct = 30;
            endcase
            idle_on = !quiet && $urandom_range(0, 3) != 0;
            allow_stall = idle_on;
            for (int j = 0; j < count; j++) begin
               if (idle_on && $urandom_range(0, 3) == 0) sender_pause($urandom_range(1, 16));
               if (storm) send_random(64, 100, 100, 0, 100);
               else send_random(span, pin_pct, 8, 4, 55);
            end
            sent += count;
         end
      end

      drain_requests();
      repeat (40) @(posedge clock);
      if (ledger.failures == 0 && ledger.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
